[sv/srec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3 record loader package
// Shared types, command codes, status codes and character constants.
// ----------------------------------------------------------------------------
package srec_pkg;

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_CHAR    = 2'd0,
		CMD_EOL     = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LEAD  = 3'd1,
		PH_TYPE  = 3'd2,
		PH_COUNT = 3'd3,
		PH_ADDR  = 3'd4,
		PH_DATA  = 3'd5,
		PH_SUM   = 3'd6,
		PH_REST  = 3'd7
	} phase_t;

	// Result kinds.
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Status codes.
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_HEADER    = 4'd1;
	localparam logic [3:0] ST_DONE      = 4'd2;
	localparam logic [3:0] ST_NO_S      = 4'd3;
	localparam logic [3:0] ST_COUNT     = 4'd4;
	localparam logic [3:0] ST_ADDR      = 4'd5;
	localparam logic [3:0] ST_DATA      = 4'd6;
	localparam logic [3:0] ST_SUM       = 4'd7;
	localparam logic [3:0] ST_TYPE      = 4'd8;
	localparam logic [3:0] ST_NO_HEADER = 4'd9;

	// Register indexes on the configuration port.
	localparam logic REG_STAGING_OFFSET = 1'b0;
	localparam logic REG_ACCEPT_LIMIT   = 1'b1;

	// Register reset values.
	localparam logic [31:0] STAGING_OFFSET_RST = 32'h0002_0000;
	localparam logic [31:0] ACCEPT_LIMIT_RST   = 32'h0002_0000;

	// Characters.
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] SUM_GOOD = 8'hFF;

	// Bytes in one address or data field.
	localparam int unsigned FIELD_BYTES = 4;

	// Hex digit value; bit 4 set marks a character that is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 5'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 5'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 5'(c - 8'h57);
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

	// Space, tab, LF, VT, FF and CR.
	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

[sv/srecord_s3_loader_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3 record loader
// Parses S-record text one character per transfer and issues word writes
// into a staging area, plus record and session status results.
// ----------------------------------------------------------------------------
// The loader takes one character, line end or restart command per clock.
// Each input transfer is captured in an input register and decoded against
// the parser state while it sits there. Its result is then loaded into the
// output register, which drives the output transfer, so a result passes
// through both registers before it can leave.
// An input transfer causes at most one result. The input is stalled while an
// item waits in the input register and a result is held in the output
// register by a stalled consumer, whether or not that item has a result of
// its own; otherwise throughput is one item per clock. The user must write
// staging offset and accept limit through the APB port only while no session
// traffic is in flight; the block itself does not enforce this.
module srecord_s3_loader_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  ch,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_kind,
	output logic [31:0] write_address,
	output logic [31:0] write_data,
	output logic [3:0]  status,
	output logic        session_over,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import srec_pkg::*;

	// Configuration registers.
	logic [31:0] staging_offset_q;
	logic [31:0] accept_limit_q;

	// Input stage.
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [7:0]  ch_s1;

	// Parser state.
	phase_t      phase_q, phase_d;
	logic        header_q, header_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [31:0] rec_addr_q, rec_addr_d;
	logic [31:0] word_q, word_d;
	logic [7:0]  sum_q, sum_d;
	logic [3:0]  hi_q, hi_d;
	logic        pend_q, pend_d;
	logic [1:0]  bif_q, bif_d;

	// Result of the current item.
	logic        emit;
	logic        res_kind;
	logic [31:0] res_addr;
	logic [31:0] res_data;
	logic [3:0]  res_code;
	logic        res_over;

	// Output register.
	logic        out_valid_q;
	logic        out_kind_q;
	logic [31:0] out_addr_q;
	logic [31:0] out_data_q;
	logic [3:0]  out_code_q;
	logic        out_over_q;

	logic        advance;
	logic        cfg_write;
	logic [7:0]  chr;
	logic [4:0]  digit;
	logic [7:0]  byte_v;
	logic [7:0]  sum_new;
	logic [31:0] word_new;
	logic [3:0]  hex_err_code;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			staging_offset_q <= STAGING_OFFSET_RST;
			accept_limit_q   <= ACCEPT_LIMIT_RST;
		end else if (cfg_write) begin
			if (paddr[2] == REG_STAGING_OFFSET) begin
				staging_offset_q <= pwdata;
			end else begin
				accept_limit_q <= pwdata;
			end
		end
	end

	// Configuration readback.
	assign prdata = (paddr[2] == REG_ACCEPT_LIMIT) ? accept_limit_q : staging_offset_q;

	// The captured item moves on unless a held result blocks the output register.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1 <= cmd_t'(cmd);
			ch_s1  <= ch;
		end
	end

	// Character as seen by the parser; a line end reads as a NUL.
	assign chr      = (cmd_s1 == CMD_EOL) ? CH_NUL : ch_s1;
	assign digit    = hex_value(chr);
	assign byte_v   = {hi_q, digit[3:0]};
	assign sum_new  = sum_q + byte_v;
	assign word_new = {word_q[23:0], byte_v};

	// Error status of the hex field being parsed.
	always_comb begin
		case (phase_q)
			PH_COUNT: hex_err_code = ST_COUNT;
			PH_ADDR:  hex_err_code = ST_ADDR;
			PH_DATA:  hex_err_code = ST_DATA;
			default:  hex_err_code = ST_SUM;
		endcase
	end

	// Next parser state and result of the captured item.
	always_comb begin
		phase_d      = phase_q;
		header_d     = header_q;
		bytes_left_d = bytes_left_q;
		rec_addr_d   = rec_addr_q;
		word_d       = word_q;
		sum_d        = sum_q;
		hi_d         = hi_q;
		pend_d       = pend_q;
		bif_d        = bif_q;
		emit         = 1'b0;
		res_kind     = KIND_STATUS;
		res_addr     = '0;
		res_data     = '0;
		res_code     = ST_OK;
		res_over     = 1'b0;

		if (cmd_s1 == CMD_RESTART) begin
			// Restart clears everything and waits for a line.
			header_d     = 1'b0;
			bytes_left_d = '0;
			rec_addr_d   = '0;
			word_d       = '0;
			sum_d        = '0;
			hi_d         = '0;
			pend_d       = 1'b0;
			bif_d        = '0;
			phase_d      = PH_LEAD;
		end else if (cmd_s1 != CMD_UNUSED && phase_q != PH_IDLE) begin
			if (cmd_s1 == CMD_EOL && (phase_q == PH_LEAD || phase_q == PH_REST)) begin
				phase_d = PH_LEAD;
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
					end
					PH_LEAD: begin
						if (!is_blank(chr)) begin
							if (chr != CH_S) begin
								emit     = 1'b1;
								res_code = ST_NO_S;
								res_over = 1'b1;
							end else begin
								bytes_left_d = '0;
								rec_addr_d   = '0;
								word_d       = '0;
								sum_d        = '0;
								hi_d         = '0;
								pend_d       = 1'b0;
								bif_d        = '0;
								phase_d      = PH_TYPE;
							end
						end
					end
					PH_TYPE: begin
						if (chr == CH_0) begin
							header_d = 1'b1;
							phase_d  = PH_REST;
							emit     = 1'b1;
							res_code = ST_HEADER;
						end else if (chr == CH_3) begin
							phase_d = PH_COUNT;
						end else if (chr == CH_7) begin
							emit     = 1'b1;
							res_code = header_q ? ST_DONE : ST_NO_HEADER;
							res_over = 1'b1;
						end else begin
							emit     = 1'b1;
							res_code = ST_TYPE;
							res_over = 1'b1;
						end
					end
					PH_REST: begin
					end
					default: begin
						// Hex byte fields: count, address, data and checksum.
						if (digit[4]) begin
							emit     = 1'b1;
							res_code = hex_err_code;
							res_over = 1'b1;
						end else if (!pend_q) begin
							hi_d   = digit[3:0];
							pend_d = 1'b1;
						end else begin
							pend_d = 1'b0;
							sum_d  = sum_new;
							case (phase_q)
								PH_COUNT: begin
									if (byte_v < 8'd5 || byte_v[1:0] != 2'b01) begin
										emit     = 1'b1;
										res_code = ST_COUNT;
										res_over = 1'b1;
									end else begin
										bytes_left_d = byte_v - 8'd5;
										bif_d        = '0;
										rec_addr_d   = '0;
										phase_d      = PH_ADDR;
									end
								end
								PH_ADDR: begin
									rec_addr_d = {rec_addr_q[23:0], byte_v};
									if (bif_q == 2'(FIELD_BYTES - 1)) begin
										bif_d   = '0;
										phase_d = (bytes_left_q != '0) ? PH_DATA : PH_SUM;
									end else begin
										bif_d = bif_q + 2'd1;
									end
								end
								PH_DATA: begin
									word_d       = word_new;
									bytes_left_d = bytes_left_q - 8'd1;
									if (bif_q != 2'(FIELD_BYTES - 1)) begin
										bif_d = bif_q + 2'd1;
									end else begin
										// A full word: write it if it lies below the limit.
										bif_d = '0;
										if (rec_addr_q < accept_limit_q) begin
											emit     = 1'b1;
											res_kind = KIND_WRITE;
											res_addr = staging_offset_q + rec_addr_q;
											res_data = word_new;
										end
										rec_addr_d = rec_addr_q + 32'(FIELD_BYTES);
										if (bytes_left_q == 8'd1) begin
											phase_d = PH_SUM;
										end
									end
								end
								default: begin
									emit = 1'b1;
									if (sum_new != SUM_GOOD) begin
										res_code = ST_SUM;
										res_over = 1'b1;
									end else begin
										res_code = ST_OK;
										phase_d  = PH_REST;
									end
								end
							endcase
						end
					end
				endcase
				if (emit && res_over) begin
					phase_d = PH_IDLE;
				end
			end
		end
	end

	// Parser state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			header_q     <= 1'b0;
			bytes_left_q <= '0;
			rec_addr_q   <= '0;
			word_q       <= '0;
			sum_q        <= '0;
			hi_q         <= '0;
			pend_q       <= 1'b0;
			bif_q        <= '0;
		end else if (advance) begin
			phase_q      <= phase_d;
			header_q     <= header_d;
			bytes_left_q <= bytes_left_d;
			rec_addr_q   <= rec_addr_d;
			word_q       <= word_d;
			sum_q        <= sum_d;
			hi_q         <= hi_d;
			pend_q       <= pend_d;
			bif_q        <= bif_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_kind_q <= res_kind;
			out_addr_q <= res_addr;
			out_data_q <= res_data;
			out_code_q <= res_code;
			out_over_q <= res_over;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_kind      = out_kind_q;
	assign write_address = out_addr_q;
	assign write_data    = out_data_q;
	assign status        = out_code_q;
	assign session_over  = out_over_q;

	// A write request never carries a status or ends the session.
	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == KIND_WRITE) |-> (!session_over && status == ST_OK))
		else $error("write request carries status or session end");

	// The input is stalled only while a result waits in the output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with no waiting result");

	// A result that ends the session leaves the parser idle.
	a_over_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && res_over) |=> (phase_q == PH_IDLE))
		else $error("session end did not return parser to idle");

	// A loaded result is presented on the next cycle.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (out_valid && out_kind == $past(res_kind)))
		else $error("result not presented after load");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S3 record loader testbench
// Feeds S-record text, line ends and restarts into the loader, and predicts
// every word write and status in step with the input transfers. Each output
// transfer is checked field by field against the oldest prediction. Staging
// offset and accept limit are changed between runs of traffic, and both
// channels see random bursts of idle and stall cycles in all but the last run.
// ----------------------------------------------------------------------------
module tb;
	import srec_pkg::*;

	// Cycles that the loader may still need after its last input transfer.
	localparam int SETTLE_CYCLES = 8;
	// Address and checksum bytes counted in every S3 record.
	localparam logic [7:0] COUNT_OVERHEAD = 8'd5;
	// Largest number of data words that an 8-bit count allows.
	localparam int MAX_WORDS = 62;
	// Input transfers queued over the whole run, directed lines included.
	localparam int ITEM_TARGET = 880;
	// Register settings that the random traffic is split across.
	localparam int SETTING_RUNS = 5;
	// Printing stops after this many mismatch lines; counting goes on.
	localparam int PRINT_CAP = 40;

	typedef struct {
		cmd_t       op;
		logic [7:0] ch;
	} loader_item_t;

	typedef struct {
		logic        kind;
		logic [31:0] addr;
		logic [31:0] data;
		logic [3:0]  code;
		logic        over;
	} loader_out_t;

	// Ways in which a generated S3 record is damaged.
	typedef enum int {
		FAULT_NONE,
		FAULT_SUM,
		FAULT_COUNT,
		FAULT_DIGIT,
		FAULT_SHORT
	} record_fault_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_CHAR;
	logic [7:0]  ch = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        out_kind;
	logic [31:0] write_address;
	logic [31:0] write_data;
	logic [3:0]  status;
	logic        session_over;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	srecord_s3_loader_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.ch           (ch),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_kind     (out_kind),
		.write_address(write_address),
		.write_data   (write_data),
		.status       (status),
		.session_over (session_over),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Stimulus and prediction bookkeeping.
	loader_item_t stim_queue[$];
	loader_out_t  due_results[$];
	loader_item_t held_item;
	logic         drive_valid;
	bit           bursts_on = 1'b1;
	int           send_gap = 0;
	int           stall_left = 0;
	int           queued_count = 0;
	int           items_accepted = 0;
	int           writes_seen = 0;
	int           statuses_seen = 0;
	int           settings_used = 1;
	int           mismatch_count = 0;

	// Predicted loader state and its copy of the registers.
	logic [31:0]  staging_base = STAGING_OFFSET_RST;
	logic [31:0]  limit_addr = ACCEPT_LIMIT_RST;
	phase_t       parse_phase = PH_IDLE;
	logic         hdr_seen = 1'b0;
	logic [7:0]   bytes_due = 8'd0;
	logic [31:0]  rec_addr = 32'd0;
	logic [31:0]  word_acc = 32'd0;
	logic [7:0]   byte_total = 8'd0;
	logic [3:0]   hi_nib = 4'd0;
	logic         nib_held = 1'b0;
	logic [1:0]   field_pos = 2'd0;

	// Clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hex digit value, with bit 4 set for anything that is not a hex digit.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 5'(c - "0");
		if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
		if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
		return 5'h10;
	endfunction

	function automatic bit blank_char(input logic [7:0] c);
		case (c)
			8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Status for a bad character inside a hex field.
	function automatic logic [3:0] field_error(input phase_t p);
		case (p)
			PH_COUNT: return ST_COUNT;
			PH_ADDR:  return ST_ADDR;
			PH_DATA:  return ST_DATA;
			default:  return ST_SUM;
		endcase
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	task automatic clear_fields();
		bytes_due = 8'd0;
		rec_addr = 32'd0;
		word_acc = 32'd0;
		byte_total = 8'd0;
		hi_nib = 4'd0;
		nib_held = 1'b0;
		field_pos = 2'd0;
	endtask

	task automatic post_status(input logic [3:0] code, input logic over);
		loader_out_t r;
		r.kind = KIND_STATUS;
		r.addr = 32'd0;
		r.data = 32'd0;
		r.code = code;
		r.over = over;
		due_results.push_back(r);
		if (over)
			parse_phase = PH_IDLE;
	endtask

	// Advances the predicted parser by one accepted input transfer.
	task automatic parse_transfer(input loader_item_t it);
		logic [7:0]  c;
		logic [4:0]  nib;
		logic [7:0]  b;
		loader_out_t w;
		c = it.ch;
		if (it.op == CMD_RESTART) begin
			hdr_seen = 1'b0;
			clear_fields();
			parse_phase = PH_LEAD;
			return;
		end
		if (it.op == CMD_UNUSED || parse_phase == PH_IDLE)
			return;
		// A line end ends a header, record or blank line; elsewhere it is a bad character.
		if (it.op == CMD_EOL) begin
			if (parse_phase == PH_LEAD || parse_phase == PH_REST) begin
				parse_phase = PH_LEAD;
				return;
			end
			c = CH_NUL;
		end
		case (parse_phase)
			PH_LEAD: begin
				if (blank_char(c))
					return;
				if (c != CH_S) begin
					post_status(ST_NO_S, 1'b1);
					return;
				end
				clear_fields();
				parse_phase = PH_TYPE;
				return;
			end
			PH_TYPE: begin
				if (c == CH_0) begin
					hdr_seen = 1'b1;
					parse_phase = PH_REST;
					post_status(ST_HEADER, 1'b0);
				end else if (c == CH_3) begin
					parse_phase = PH_COUNT;
				end else if (c == CH_7) begin
					post_status(hdr_seen ? ST_DONE : ST_NO_HEADER, 1'b1);
				end else begin
					post_status(ST_TYPE, 1'b1);
				end
				return;
			end
			PH_REST: return;
			default: ;
		endcase

		// Hex byte fields: count, address, data and checksum.
		nib = hex_nibble(c);
		if (nib[4]) begin
			post_status(field_error(parse_phase), 1'b1);
			return;
		end
		if (!nib_held) begin
			hi_nib = nib[3:0];
			nib_held = 1'b1;
			return;
		end
		nib_held = 1'b0;
		b = {hi_nib, nib[3:0]};
		byte_total = byte_total + b;

		case (parse_phase)
			PH_COUNT: begin
				// Count covers address and checksum plus whole data words.
				if (b < COUNT_OVERHEAD || b[1:0] != COUNT_OVERHEAD[1:0]) begin
					post_status(ST_COUNT, 1'b1);
					return;
				end
				bytes_due = b - COUNT_OVERHEAD;
				field_pos = 2'd0;
				rec_addr = 32'd0;
				parse_phase = PH_ADDR;
			end
			PH_ADDR: begin
				rec_addr = {rec_addr[23:0], b};
				if (field_pos == 2'(FIELD_BYTES - 1)) begin
					field_pos = 2'd0;
					parse_phase = (bytes_due != 8'd0) ? PH_DATA : PH_SUM;
				end else begin
					field_pos++;
				end
			end
			PH_DATA: begin
				word_acc = {word_acc[23:0], b};
				bytes_due--;
				if (field_pos != 2'(FIELD_BYTES - 1)) begin
					field_pos++;
					return;
				end
				field_pos = 2'd0;
				// Whole word: written only below the accept limit.
				if (rec_addr < limit_addr) begin
					w.kind = KIND_WRITE;
					w.addr = staging_base + rec_addr;
					w.data = word_acc;
					w.code = ST_OK;
					w.over = 1'b0;
					due_results.push_back(w);
				end
				rec_addr = rec_addr + 32'(FIELD_BYTES);
				if (bytes_due == 8'd0)
					parse_phase = PH_SUM;
			end
			default: begin
				if (byte_total != SUM_GOOD) begin
					post_status(ST_SUM, 1'b1);
				end else begin
					parse_phase = PH_REST;
					post_status(ST_OK, 1'b0);
				end
			end
		endcase
	endtask

	// Input driver: one transfer per accepted item, with random idle bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			drive_valid = in_valid;
			if (in_valid && !in_stall) begin
				parse_transfer(held_item);
				items_accepted++;
				drive_valid = 1'b0;
			end
			if (!drive_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (bursts_on && stim_queue.size() != 0 &&
						$urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 12);
				end else if (stim_queue.size() != 0) begin
					held_item = stim_queue.pop_front();
					cmd <= held_item.op;
					ch <= held_item.ch;
					drive_valid = 1'b1;
				end
			end
			in_valid <= drive_valid;
		end
	end

	// Output monitor: checks each result transfer and stalls in random bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_output();
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (bursts_on && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 12);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic check_output();
		loader_out_t want;
		if (due_results.size() == 0) begin
			flag_mismatch($sformatf("result with nothing expected: kind %0d status %0d",
				out_kind, status));
			return;
		end
		want = due_results.pop_front();
		if (out_kind !== want.kind)
			flag_mismatch($sformatf("out_kind %0d, expected %0d", out_kind, want.kind));
		if (write_address !== want.addr)
			flag_mismatch($sformatf("write_address %h, expected %h", write_address, want.addr));
		if (write_data !== want.data)
			flag_mismatch($sformatf("write_data %h, expected %h", write_data, want.data));
		if (status !== want.code)
			flag_mismatch($sformatf("status %0d, expected %0d", status, want.code));
		if (session_over !== want.over)
			flag_mismatch($sformatf("session_over %0d, expected %0d", session_over, want.over));
		if (want.kind == KIND_WRITE)
			writes_seen++;
		else
			statuses_seen++;
	endtask

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_transfer(input bit is_write, input logic idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Reads a register back and compares it with the value it should hold.
	task automatic verify_register(input logic idx, input logic [31:0] want);
		logic [31:0] got;
		apb_transfer(1'b0, idx, 32'd0, got);
		if (got !== want)
			flag_mismatch($sformatf("register %0d reads %h, expected %h", idx, got, want));
	endtask

	task automatic set_registers(input logic [31:0] offset, input logic [31:0] limit);
		logic [31:0] unused;
		apb_transfer(1'b1, REG_STAGING_OFFSET, offset, unused);
		apb_transfer(1'b1, REG_ACCEPT_LIMIT, limit, unused);
		staging_base = offset;
		limit_addr = limit;
		verify_register(REG_STAGING_OFFSET, offset);
		verify_register(REG_ACCEPT_LIMIT, limit);
		settings_used++;
	endtask

	// Waits until every queued item is taken and every result has arrived.
	task automatic drain_loader();
		while (stim_queue.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---- Stimulus building ----

	task automatic put_item(input cmd_t op, input logic [7:0] c);
		loader_item_t it;
		it.op = op;
		it.ch = c;
		stim_queue.push_back(it);
		queued_count++;
	endtask

	task automatic put_char(input logic [7:0] c);
		put_item(CMD_CHAR, c);
	endtask

	task automatic put_eol();
		put_item(CMD_EOL, 8'($urandom));
	endtask

	task automatic put_restart();
		put_item(CMD_RESTART, 8'($urandom));
	endtask

	task automatic put_blanks(input int n);
		repeat (n) put_char($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)));
	endtask

	// Hex digit character with random letter case.
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return "0" + 8'(v);
		return ($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		logic [4:0] v;
		do begin
			c = 8'($urandom);
			v = hex_nibble(c);
		end while (!v[4]);
		return c;
	endfunction

	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return limit_addr - 32'(FIELD_BYTES * $urandom_range(0, 3));
			2: return 32'($urandom_range(0, 64));
			3: return 32'hFFFF_FFFC - 32'(FIELD_BYTES * $urandom_range(0, 2));
			default: return (limit_addr == 32'd0) ? 32'd0 : $urandom_range(0, limit_addr - 1);
		endcase
	endfunction

	function automatic int pick_words();
		case ($urandom_range(0, 29))
			0: return MAX_WORDS;
			1, 2, 3: return $urandom_range(5, 20);
			default: return $urandom_range(0, 4);
		endcase
	endfunction

	// One S3 line, optionally damaged in one way.
	task automatic put_s3(input logic [31:0] addr, input int words, input record_fault_t fault,
			input bit extreme_data);
		logic [7:0]  rec[$];
		logic [7:0]  digits[$];
		logic [7:0]  total;
		logic [31:0] w;
		int          i;
		int          k;
		int          cut;
		rec.push_back(COUNT_OVERHEAD + 8'(FIELD_BYTES * words));
		for (i = 3; i >= 0; i--) rec.push_back(addr[8*i +: 8]);
		for (k = 0; k < words; k++) begin
			if (extreme_data)
				w = k[0] ? 32'h0000_0000 : 32'hFFFF_FFFF;
			else
				w = $urandom;
			for (i = 3; i >= 0; i--) rec.push_back(w[8*i +: 8]);
		end
		total = 8'd0;
		foreach (rec[j]) total += rec[j];
		rec.push_back(~total);
		if (fault == FAULT_SUM)
			rec[rec.size() - 1] ^= 8'($urandom_range(1, 255));
		if (fault == FAULT_COUNT)
			rec[0] = 8'($urandom);
		foreach (rec[j]) begin
			digits.push_back(hex_char(rec[j][7:4]));
			digits.push_back(hex_char(rec[j][3:0]));
		end
		cut = $urandom_range(0, digits.size() - 1);
		if (fault == FAULT_DIGIT)
			digits[cut] = junk_char();
		if (fault == FAULT_SHORT)
			while (digits.size() > cut) void'(digits.pop_back());
		put_blanks($urandom_range(0, 3));
		put_char(CH_S);
		put_char(CH_3);
		foreach (digits[j]) put_char(digits[j]);
		// Trailing text after the checksum is ignored by the loader.
		if (fault != FAULT_SHORT && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) put_char(8'($urandom));
		put_eol();
	endtask

	task automatic put_typed_line(input logic [7:0] rec_type);
		put_blanks($urandom_range(0, 2));
		put_char(CH_S);
		put_char(rec_type);
		repeat ($urandom_range(0, 8)) put_char(8'($urandom));
		put_eol();
	endtask

	task automatic put_noise(input int n);
		repeat (n) begin
			case ($urandom_range(0, 15))
				0: put_restart();
				1: put_item(CMD_UNUSED, 8'($urandom));
				2: put_eol();
				default: put_char(8'($urandom));
			endcase
		end
	endtask

	// Restart, optional header, one to six lines, an ending line, then optional noise.
	task automatic put_session();
		logic [7:0] c;
		put_restart();
		if ($urandom_range(0, 9) < 8)
			put_typed_line(CH_0);
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 19))
				0: put_eol();
				1: begin
					put_blanks($urandom_range(1, 4));
					put_eol();
				end
				2: put_typed_line(CH_0);
				3, 4: put_s3(pick_address(), pick_words(),
					record_fault_t'($urandom_range(FAULT_SUM, FAULT_SHORT)), 1'b0);
				default: put_s3(pick_address(), pick_words(), FAULT_NONE,
					$urandom_range(0, 9) == 0);
			endcase
		end
		case ($urandom_range(0, 9))
			0: begin
				do c = 8'($urandom); while (blank_char(c) || c == CH_S);
				put_blanks($urandom_range(0, 2));
				put_char(c);
				put_eol();
			end
			1: begin
				do c = 8'($urandom); while (c == CH_0 || c == CH_3 || c == CH_7);
				put_typed_line(c);
			end
			2: begin
				put_char(CH_S);
				put_eol();
			end
			default: put_typed_line(CH_7);
		endcase
		if ($urandom_range(0, 3) == 0)
			put_noise($urandom_range(1, 6));
	endtask

	// Queues at least one session or noise run, and more until the total reaches upto.
	task automatic put_random(input int upto);
		do begin
			if ($urandom_range(0, 9) == 0)
				put_noise($urandom_range(1, 8));
			else
				put_session();
		end while (queued_count < upto);
	endtask

	task automatic put_directed();
		// No session yet: everything but a restart is dropped.
		put_item(CMD_UNUSED, 8'hFF);
		put_char(CH_S);
		put_eol();
		// End record without a header.
		put_restart();
		put_typed_line(CH_7);
		// Blanks followed by something other than S.
		put_restart();
		put_blanks(3);
		put_char("x");
		put_eol();
		// Line end where the record type belongs, then an unknown type.
		put_restart();
		put_char(CH_S);
		put_eol();
		put_restart();
		put_typed_line("9");
		// Header, empty and blank lines, records at the field extremes.
		put_restart();
		put_eol();
		put_blanks(2);
		put_eol();
		put_typed_line(CH_0);
		put_item(CMD_UNUSED, 8'h00);
		put_s3(32'h0000_0000, 1, FAULT_NONE, 1'b1);
		put_s3(ACCEPT_LIMIT_RST - 32'(FIELD_BYTES), 2, FAULT_NONE, 1'b1);
		put_s3(32'hFFFF_FFFF, 0, FAULT_NONE, 1'b0);
		put_typed_line(CH_7);
		// Count too small, count not a whole number of words.
		put_restart();
		put_char(CH_S);
		put_char(CH_3);
		put_char("0");
		put_char("4");
		put_eol();
		put_restart();
		put_char(CH_S);
		put_char(CH_3);
		put_char("F");
		put_char("f");
		put_eol();
		// Bad checksum, bad digit, line end inside a field.
		put_restart();
		put_s3(32'h0000_1000, 1, FAULT_SUM, 1'b0);
		put_restart();
		put_s3(32'h0000_1000, 2, FAULT_DIGIT, 1'b0);
		put_restart();
		put_s3(32'h0000_1000, 2, FAULT_SHORT, 1'b0);
	endtask

	// Main sequence: reset, directed lines, then random traffic per register setting.
	initial begin
		int run_base;
		int run_step;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_register(REG_STAGING_OFFSET, STAGING_OFFSET_RST);
		verify_register(REG_ACCEPT_LIMIT, ACCEPT_LIMIT_RST);
		put_directed();
		run_base = queued_count;
		run_step = (ITEM_TARGET - run_base) / SETTING_RUNS;
		for (int p = 0; p < SETTING_RUNS; p++) begin
			if (p > 0) begin
				// Hold the sender until every pending result has come out.
				drain_loader();
				case (p)
					1: set_registers(32'h0000_0000, 32'h0000_0000);
					2: set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
					3: set_registers($urandom, $urandom);
					default: begin
						set_registers($urandom, $urandom_range(0, 32'h0010_0000));
						bursts_on = 1'b0;
					end
				endcase
			end
			put_random(run_base + (p + 1) * run_step);
		end
		drain_loader();
		if (due_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", due_results.size()));
		$display("Run covered %0d input transfers under %0d register settings.",
			items_accepted, settings_used);
		$display("Checked %0d word writes and %0d status results, %0d mismatches.",
			writes_seen, statuses_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5ms;
		$display("Timeout: loader traffic did not complete");
		$display("Some tests failed");
		$finish;
	end

endmodule
